>>> rtl/mrde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrde_pkg
// Shared types and constants of the raster draw engine: request codes,
// controller states, the command and status records between controller and
// datapath, and the default frame geometry.
// ----------------------------------------------------------------------------
package mrde_pkg;

  localparam int ROWS_DEF      = 240;
  localparam int COLS_DEF      = 320;
  localparam int WORD_BITS_DEF = 32;

  localparam int XW = 8;
  localparam int YW = 9;
  localparam int RW = 9;
  localparam int DW = 32;
  localparam int CW = 12;

  typedef enum logic [2:0] {
    REQ_PIXEL  = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_LINE   = 3'd2,
    REQ_RECT   = 3'd3,
    REQ_CIRCLE = 3'd4,
    REQ_READ   = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_LINE_DIV,
    ST_LINE_PLOT,
    ST_RECT,
    ST_CIRC_PLOT,
    ST_CIRC_STEP,
    ST_PX_READ,
    ST_PX_WRITE,
    ST_RD_WAIT,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    PX_NONE,
    PX_LINE,
    PX_RECT,
    PX_CIRC,
    PX_SINGLE
  } pxsrc_t;

  typedef struct packed {
    logic   load;
    logic   clr_start;
    logic   clr_step;
    logic   line_init;
    logic   div_start;
    logic   line_next;
    logic   rect_init;
    logic   rect_next;
    logic   circ_init;
    logic   circ_step;
    logic   oct_next;
    pxsrc_t px_src;
    logic   px_rd;
    logic   px_wr;
    logic   word_rd;
    logic   word_cap;
    logic   set_status;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic line_done;
    logic line_bad;
    logic line_trivial;
    logic rect_done;
    logic oct_last;
    logic circ_done;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/mrde_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrde_ctrl
// Controller of the raster draw engine. It sequences the clearing pass,
// shape walks, pixel read-modify-writes, word reads and the result handshake.
// ----------------------------------------------------------------------------
module mrde_ctrl
  import mrde_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  wire   [2:0] in_req_type,
  output logic  out_valid,
  input  wire   out_ready,
  output cmd_t  cmd,
  input  stat_t st
);

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  pxsrc_t back_r, back_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      req_r   <= REQ_PIXEL;
      back_r  <= PX_NONE;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
      back_r  <= back_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    back_nxt  = back_r;
    cmd       = '0;
    cmd.px_src = PX_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          req_nxt   = req_t'(in_req_type);
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (req_r)
          REQ_PIXEL: begin
            back_nxt  = PX_SINGLE;
            state_nxt = ST_PX_READ;
          end
          REQ_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_nxt = ST_CLEAR;
          end
          REQ_LINE: begin
            cmd.line_init = 1'b1;
            state_nxt = ST_LINE_DIV;
          end
          REQ_RECT: begin
            cmd.rect_init = 1'b1;
            state_nxt = ST_RECT;
          end
          REQ_CIRCLE: begin
            cmd.circ_init = 1'b1;
            state_nxt = ST_CIRC_PLOT;
          end
          REQ_READ: begin
            cmd.word_rd = 1'b1;
            state_nxt = ST_RD_WAIT;
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_nxt = ST_RESULT;
      end
      ST_LINE_DIV: begin
        if (st.line_bad) begin
          cmd.set_status = 1'b1;
          state_nxt = ST_RESULT;
        end else if (st.line_done) begin
          state_nxt = ST_RESULT;
        end else if (st.line_trivial || st.div_done) begin
          back_nxt  = PX_LINE;
          state_nxt = ST_PX_READ;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      ST_LINE_PLOT: begin
        cmd.line_next = 1'b1;
        state_nxt = ST_LINE_DIV;
      end
      ST_RECT: begin
        if (st.rect_done) state_nxt = ST_RESULT;
        else begin
          back_nxt  = PX_RECT;
          state_nxt = ST_PX_READ;
        end
      end
      ST_CIRC_PLOT: begin
        if (st.circ_done) state_nxt = ST_RESULT;
        else begin
          back_nxt  = PX_CIRC;
          state_nxt = ST_PX_READ;
        end
      end
      ST_CIRC_STEP: begin
        cmd.circ_step = 1'b1;
        state_nxt = ST_CIRC_PLOT;
      end
      ST_PX_READ: begin
        cmd.px_src = back_r;
        cmd.px_rd  = 1'b1;
        state_nxt  = ST_PX_WRITE;
      end
      ST_PX_WRITE: begin
        cmd.px_src = back_r;
        cmd.px_wr  = 1'b1;
        case (back_r)
          PX_LINE: state_nxt = ST_LINE_PLOT;
          PX_RECT: begin
            cmd.rect_next = 1'b1;
            state_nxt = ST_RECT;
          end
          PX_CIRC: begin
            cmd.oct_next = 1'b1;
            state_nxt = st.oct_last ? ST_CIRC_STEP : ST_CIRC_PLOT;
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_RD_WAIT: begin
        cmd.word_cap = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !in_ready && !out_valid)
    else $error("handshake active during clearing pass");
  a_ready_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request and result both open");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.px_wr |-> $past(cmd.px_rd))
    else $error("pixel write without prior read");

endmodule
`default_nettype wire

>>> rtl/mrde_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrde_dp
// Datapath of the raster draw engine: request registers, the frame store,
// a clearing sweep, the line walker with a serial divider, the rectangle
// walker, the midpoint circle walker and the pixel read-modify-write port.
// ----------------------------------------------------------------------------
module mrde_dp
  import mrde_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int COLS      = COLS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
)(
  input  wire              clk,
  input  wire              rst_n,
  input  wire [XW-1:0]     in_x_a,
  input  wire [YW-1:0]     in_y_a,
  input  wire [XW-1:0]     in_x_b,
  input  wire [YW-1:0]     in_y_b,
  input  wire [RW-1:0]     in_radius,
  input  wire              in_fill,
  input  cmd_t             cmd,
  output stat_t            st,
  output logic             out_status,
  output logic [DW-1:0]    out_read_data
);

  localparam int WPR   = (COLS + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH = ROWS * WPR;
  localparam int AW    = $clog2(DEPTH + 1);
  localparam int BW    = $clog2(WORD_BITS);
  localparam int SW    = 13;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  logic [XW-1:0] xa_r, xb_r;
  logic [YW-1:0] ya_r, yb_r;
  logic [RW-1:0] rad_r;
  logic          fill_r;
  logic          status_r;
  logic [DW-1:0] rdw_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xa_r   <= in_x_a;
      ya_r   <= in_y_a;
      xb_r   <= in_x_b;
      yb_r   <= in_y_b;
      rad_r  <= in_radius;
      fill_r <= in_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) status_r <= 1'b0;
    else if (cmd.load) status_r <= 1'b0;
    else if (cmd.set_status) status_r <= 1'b1;
  end

  // Clearing sweep.
  logic [AW-1:0] clr_r;
  logic          clr_busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (cmd.clr_start) begin
      clr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (cmd.clr_step && clr_busy_r) begin
      if (clr_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
      clr_r <= clr_r + 1'b1;
    end
  end

  // Line walker.
  logic signed [SW-1:0] dr, dc;
  logic                 l_hor_r, l_ver_r, l_rmaj_r, l_eq_r;
  logic [9:0]           li_r, lmaj_r, lmin_r;
  logic [9:0]           loff_r;
  logic [20:0]          num_r, rem_r;
  logic [4:0]           dcnt_r;
  logic                 dbusy_r, ddone_r;

  assign dr = SW'(signed'({1'b0, xb_r})) - SW'(signed'({1'b0, xa_r}));
  assign dc = SW'(signed'({1'b0, yb_r})) - SW'(signed'({1'b0, ya_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else if (cmd.line_init) begin
      l_hor_r  <= (xa_r == xb_r);
      l_ver_r  <= (ya_r == yb_r);
      l_rmaj_r <= (dr > dc);
      l_eq_r   <= (dr == dc);
      li_r     <= '0;
      if (dr > dc) begin
        lmaj_r <= dr[9:0];
        lmin_r <= dc[9:0];
      end else begin
        lmaj_r <= dc[9:0];
        lmin_r <= dr[9:0];
      end
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else if (cmd.line_next) begin
      li_r    <= li_r + 1'b1;
      ddone_r <= 1'b0;
    end else if (cmd.div_start && !dbusy_r && !ddone_r) begin
      num_r   <= 21'(2 * li_r * lmin_r) + 21'(lmaj_r);
      rem_r   <= '0;
      dcnt_r  <= 5'd21;
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      // Restoring division, one quotient bit per cycle.
      if ({rem_r[19:0], num_r[20]} >= {10'd0, lmaj_r, 1'b0}) begin
        rem_r <= {rem_r[19:0], num_r[20]} - {10'd0, lmaj_r, 1'b0};
        num_r <= {num_r[19:0], 1'b1};
      end else begin
        rem_r <= {rem_r[19:0], num_r[20]};
        num_r <= {num_r[19:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == 5'd1) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end
    end
  end
  assign loff_r = num_r[9:0];

  logic [10:0] l_end;
  always_comb begin
    if (l_hor_r)      l_end = {2'b0, yb_r} - {2'b0, ya_r};
    else if (l_ver_r) l_end = {3'b0, xb_r} - {3'b0, xa_r};
    else              l_end = {1'b0, lmaj_r};
  end

  logic signed [SW-1:0] l_pr, l_pc;
  always_comb begin
    l_pr = SW'(signed'({1'b0, xa_r}));
    l_pc = SW'(signed'({1'b0, ya_r}));
    if (l_hor_r)       l_pc = l_pc + SW'(li_r);
    else if (l_ver_r)  l_pr = l_pr + SW'(li_r);
    else if (l_eq_r) begin
      l_pr = l_pr + SW'(li_r);
      l_pc = l_pc + SW'(li_r);
    end else if (l_rmaj_r) begin
      l_pr = l_pr + SW'(li_r);
      l_pc = l_pc + SW'(loff_r);
    end else begin
      l_pr = l_pr + SW'(loff_r);
      l_pc = l_pc + SW'(li_r);
    end
  end

  // Rectangle walker: phase 0 walks rows with two or all columns,
  // phase 1 walks columns on the first and last rows (x_a and x_b).
  logic          rph_r;
  logic [1:0]    rsub_r;
  logic [XW:0]   ri_r;
  logic [YW:0]   rj_r;
  logic          rdone_r;
  always_ff @(posedge clk) begin
    if (cmd.rect_init) begin
      rph_r  <= 1'b0;
      rsub_r <= '0;
      ri_r   <= {1'b0, xa_r};
      rj_r   <= {1'b0, ya_r};
      rdone_r <= 1'b0;
    end else if (cmd.rect_next) begin
      if (!rph_r) begin
        if (fill_r && rsub_r == 2'd2 && rj_r < {1'b0, yb_r}) begin
          rj_r <= rj_r + 1'b1;
        end else if (rsub_r == 2'd0) rsub_r <= 2'd1;
        else if (rsub_r == 2'd1 && fill_r && ya_r <= yb_r) begin
          rsub_r <= 2'd2;
          rj_r   <= {1'b0, ya_r};
        end else begin
          rsub_r <= '0;
          ri_r   <= ri_r + 1'b1;
        end
      end else begin
        if (rsub_r == 2'd0) rsub_r <= 2'd1;
        else begin
          rsub_r <= '0;
          rj_r   <= rj_r + 1'b1;
        end
      end
    end else if (!rph_r && ri_r > {1'b0, xb_r}) begin
      rph_r  <= 1'b1;
      rsub_r <= '0;
      rj_r   <= {1'b0, ya_r};
    end else if (rph_r && rj_r > {1'b0, yb_r}) begin
      rdone_r <= 1'b1;
    end
  end

  logic signed [SW-1:0] r_pr, r_pc;
  logic                 r_ok;
  always_comb begin
    r_ok = 1'b1;
    if (!rph_r) begin
      r_pr = SW'(ri_r);
      case (rsub_r)
        2'd0:    r_pc = SW'(ya_r);
        2'd1:    r_pc = SW'(yb_r);
        default: r_pc = SW'(rj_r);
      endcase
      if (ri_r > {1'b0, xb_r}) r_ok = 1'b0;
      if (rsub_r == 2'd2 && rj_r > {1'b0, yb_r}) r_ok = 1'b0;
    end else begin
      r_pr = (rsub_r == 2'd0) ? SW'(xa_r) : SW'(xb_r);
      r_pc = SW'(rj_r);
      if (rj_r > {1'b0, yb_r}) r_ok = 1'b0;
    end
  end

  // Midpoint circle walker.
  logic signed [SW-1:0] ca_r, cb_r, cd_r;
  logic [2:0]           oct_r;
  logic                 cdone_r;
  always_ff @(posedge clk) begin
    if (cmd.circ_init) begin
      ca_r    <= '0;
      cb_r    <= SW'(rad_r);
      cd_r    <= SW'(1) - SW'(rad_r);
      oct_r   <= '0;
      cdone_r <= 1'b0;
    end else if (cmd.oct_next) begin
      oct_r <= oct_r + 1'b1;
    end else if (cmd.circ_step) begin
      if (ca_r >= cb_r) cdone_r <= 1'b1;
      else begin
        if (cd_r < 0) cd_r <= cd_r + (ca_r <<< 1) + SW'(3);
        else begin
          cd_r <= cd_r + ((ca_r - cb_r) <<< 1) + SW'(5);
          cb_r <= cb_r - SW'(1);
        end
        ca_r <= ca_r + SW'(1);
      end
    end
  end

  logic signed [SW-1:0] c_pr, c_pc, c_u, c_v, c_cr, c_cc;
  always_comb begin
    c_cr = SW'(xa_r);
    c_cc = SW'(ya_r);
    c_u  = oct_r[2] ? cb_r : ca_r;
    c_v  = oct_r[2] ? ca_r : cb_r;
    c_pr = oct_r[1] ? c_cr - c_u : c_cr + c_u;
    c_pc = oct_r[0] ? c_cc - c_v : c_cc + c_v;
  end

  // Status toward the controller.
  always_comb begin
    st.clr_done     = cmd.clr_step && clr_busy_r && (clr_r == AW'(DEPTH - 1));
    st.div_done     = ddone_r;
    st.line_bad     = !l_hor_r && !l_ver_r && (dr < 0 || dc < 0);
    st.line_done    = (l_hor_r && ya_r > yb_r) || (!l_hor_r && l_ver_r && xa_r > xb_r)
                   || ({1'b0, li_r} > l_end);
    st.line_trivial = l_hor_r || l_ver_r || l_eq_r;
    st.rect_done    = rdone_r;
    st.oct_last     = (oct_r == 3'd7);
    st.circ_done    = cdone_r;
  end

  // Pixel read-modify-write.
  logic signed [SW-1:0] p_r, p_c;
  logic                 p_ok;
  always_comb begin
    p_ok = 1'b1;
    case (cmd.px_src)
      PX_LINE: begin
        p_r = l_pr;
        p_c = l_pc;
      end
      PX_RECT: begin
        p_r = r_pr;
        p_c = r_pc;
        p_ok = r_ok;
      end
      PX_CIRC: begin
        p_r = c_pr;
        p_c = c_pc;
      end
      default: begin
        p_r = SW'(xa_r);
        p_c = SW'(ya_r);
      end
    endcase
  end

  logic          p_in;
  logic [AW-1:0] p_addr, rd_addr;
  logic [BW-1:0] p_bit;
  assign p_in = p_ok && p_r >= 0 && p_c >= 0 && p_r < SW'(ROWS) && p_c < SW'(COLS);
  assign p_addr = AW'(p_r * SW'(WPR) + (p_c / SW'(WORD_BITS)));
  assign p_bit  = BW'(p_c % SW'(WORD_BITS));

  logic           w_ok;
  logic [AW-1:0]  w_addr;
  assign w_ok   = ({1'b0, xa_r} < 9'(ROWS)) && ((ya_r / YW'(WORD_BITS)) < YW'(WPR));
  assign w_addr = AW'(xa_r * WPR + ya_r / YW'(WORD_BITS));

  always_comb begin
    if (cmd.word_rd) rd_addr = w_addr;
    else             rd_addr = p_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step && clr_busy_r) begin
      mem[clr_r] <= '0;
    end else if (cmd.px_wr && p_in) begin
      mem[p_addr] <= rdata_r | (WORD_BITS'(1) << p_bit);
    end
    if ((cmd.px_rd || cmd.word_rd) && rd_addr < AW'(DEPTH)) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) rdw_r <= '0;
    else if (cmd.word_cap && w_ok) rdw_r <= DW'(rdata_r);
  end

  assign out_status    = status_r;
  assign out_read_data = rdw_r;

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.px_wr && p_in) |-> (p_addr < AW'(DEPTH)))
    else $error("pixel write beyond frame store");
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    ddone_r |-> !dbusy_r)
    else $error("divider busy and done together");
  a_oct_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.circ_step |-> oct_r == 3'd0)
    else $error("circle step mid octant set");

endmodule
`default_nettype wire

>>> rtl/monochrome_raster_draw_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// monochrome_raster_draw_engine
// One-bit frame store with pixel, clear, line, rectangle, circle and read
// requests.
// ----------------------------------------------------------------------------
// A request enters on in_valid/in_ready with its type, coordinates, radius
// and fill flag. Exactly one result follows on out_valid/out_ready carrying
// a status bit and, for a read, the addressed 32-pixel word.
// Requests are processed one at a time; the next request can be taken in
// the cycle after the result is accepted. Each plotted pixel costs a
// read-modify-write of the frame store (a read state, then a write state)
// plus walker control states; a line pixel that is neither straight nor
// diagonal adds a serial division, and a circle adds a step state after
// every eight pixels. A clear walks every word, ROWS*ceil(COLS/WORD_BITS)
// words (2400 by default). A read passes through the dispatch and read-wait
// states before its result, a single pixel through the dispatch, pixel read
// and pixel write states. After reset the same clearing pass runs with
// in_ready low. While out_ready is low the result is held and no new
// request is taken.
// ----------------------------------------------------------------------------
module monochrome_raster_draw_engine
  import mrde_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int COLS      = COLS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
)(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire [2:0]      in_req_type,
  input  wire [XW-1:0]   in_x_a,
  input  wire [YW-1:0]   in_y_a,
  input  wire [XW-1:0]   in_x_b,
  input  wire [YW-1:0]   in_y_b,
  input  wire [RW-1:0]   in_radius,
  input  wire            in_fill,
  output logic           out_valid,
  input  wire            out_ready,
  output logic           out_status,
  output logic [DW-1:0]  out_read_data
);

  cmd_t  cmd;
  stat_t st;

  mrde_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type,
    .out_valid, .out_ready, .cmd, .st
  );

  mrde_dp #(.ROWS(ROWS), .COLS(COLS), .WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst_n, .in_x_a, .in_y_a, .in_x_b, .in_y_b, .in_radius, .in_fill,
    .cmd, .st, .out_status, .out_read_data
  );

endmodule
`default_nettype wire
